/* design/imsd_pkg.sv */
// shared types, codes and constants for the icy metadata stream demux
// no dependencies
package imsd_pkg;

  localparam int unsigned IntervalW  = 20;
  localparam int unsigned RemainW    = 12;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PrefixLen  = 13;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned PtrW       = $clog2(FifoDepth);
  localparam int unsigned CntW       = $clog2(FifoDepth + 1);

  localparam logic [ByteW-1:0] CharS     = 8'h53;
  localparam logic [ByteW-1:0] CharQuote = 8'h27;
  localparam logic [ByteW-1:0] CharSemi  = 8'h3b;

  typedef enum logic [1:0] {
    PH_AUDIO = 2'd0,
    PH_LEN   = 2'd1,
    PH_META  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    TP_SEARCH = 2'd0,
    TP_TITLE  = 2'd1,
    TP_DONE   = 2'd2,
    TP_STOP   = 2'd3
  } title_e;

  typedef enum logic [1:0] {
    KIND_AUDIO   = 2'd0,
    KIND_TITLE   = 2'd1,
    KIND_COMMIT  = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
  } result_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    result_t [MaxResults-1:0]   item;
  } results_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             last;
  } entry_t;

  function automatic logic [ByteW-1:0] prefix_char(input logic [3:0] idx);
    logic [ByteW-1:0] c;
    case (idx)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h6d; // m
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h69; // i
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h6c; // l
      4'd10:   c = 8'h65; // e
      4'd11:   c = 8'h3d; // =
      4'd12:   c = 8'h27; // quote
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/imsd_parser.sv */
// stream parser: audio/length/metadata phases and title matcher
// produces up to three results per byte; depends on imsd_pkg
module imsd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [imsd_pkg::IntervalW-1:0] meta_interval_i,
  input  logic                          proc_i,
  input  logic [imsd_pkg::ByteW-1:0]    byte_i,
  output imsd_pkg::results_t            res_o
);
  import imsd_pkg::*;

  logic [IntervalW-1:0] audio_count_q, audio_count_d;
  phase_e               phase_q, phase_d;
  logic [RemainW-1:0]   meta_rem_q, meta_rem_d;
  logic [3:0]           prefix_q, prefix_d;
  title_e               title_q, title_d;
  logic                 quote_q, quote_d;
  logic                 nonempty_q, nonempty_d;

  logic [IntervalW:0]   count_inc;
  logic [3:0]           pidx;
  logic [3:0]           pnext;
  logic [1:0]           n;
  results_t             res;

  assign count_inc = {1'b0, audio_count_q} + (IntervalW + 1)'(1);
  assign pidx      = (prefix_q < 4'(PrefixLen)) ? prefix_q : 4'd0;
  assign pnext     = pidx + 4'd1;

  always_comb begin
    audio_count_d = audio_count_q;
    phase_d       = phase_q;
    meta_rem_d    = meta_rem_q;
    prefix_d      = prefix_q;
    title_d       = title_q;
    quote_d       = quote_q;
    nonempty_d    = nonempty_q;
    n             = 2'd0;
    res           = '0;
    if (proc_i) begin
      if (meta_interval_i == '0) begin
        res.item[n] = '{kind: KIND_AUDIO, data: byte_i};
        n = n + 2'd1;
      end else begin
        case (phase_q)
          PH_LEN: begin
            meta_rem_d = {byte_i, 4'b0000};
            if (byte_i != '0) begin
              phase_d    = PH_META;
              prefix_d   = 4'd0;
              title_d    = TP_SEARCH;
              quote_d    = 1'b0;
              nonempty_d = 1'b0;
            end else begin
              phase_d = PH_AUDIO;
            end
          end
          PH_META: begin
            case (title_q)
              TP_SEARCH: begin
                if (byte_i == '0) begin
                  title_d = TP_STOP;
                end else if (byte_i == prefix_char(pidx)) begin
                  if (pnext == 4'(PrefixLen)) begin
                    title_d  = TP_TITLE;
                    prefix_d = 4'd0;
                  end else begin
                    prefix_d = pnext;
                  end
                end else begin
                  prefix_d = (byte_i == CharS) ? 4'd1 : 4'd0;
                end
              end
              TP_TITLE: begin
                if (byte_i == '0) begin
                  title_d = TP_STOP;
                  quote_d = 1'b0;
                end else if (quote_q) begin
                  if (byte_i == CharSemi) begin
                    title_d = TP_DONE;
                    quote_d = 1'b0;
                  end else begin
                    res.item[n] = '{kind: KIND_TITLE, data: CharQuote};
                    n = n + 2'd1;
                    nonempty_d = 1'b1;
                    if (byte_i == CharQuote) begin
                      quote_d = 1'b1;
                    end else begin
                      res.item[n] = '{kind: KIND_TITLE, data: byte_i};
                      n = n + 2'd1;
                      quote_d = 1'b0;
                    end
                  end
                end else if (byte_i == CharQuote) begin
                  quote_d = 1'b1;
                end else begin
                  res.item[n] = '{kind: KIND_TITLE, data: byte_i};
                  n = n + 2'd1;
                  nonempty_d = 1'b1;
                end
              end
              default: ;
            endcase
            meta_rem_d = meta_rem_q - RemainW'(1);
            if (meta_rem_d == '0) begin
              res.item[n] = '{kind: (title_d == TP_DONE && nonempty_d) ?
                                    KIND_COMMIT : KIND_DISCARD,
                              data: '0};
              n = n + 2'd1;
              phase_d = PH_AUDIO;
            end
          end
          default: begin
            res.item[n] = '{kind: KIND_AUDIO, data: byte_i};
            n = n + 2'd1;
            if (count_inc >= {1'b0, meta_interval_i}) begin
              audio_count_d = '0;
              phase_d       = PH_LEN;
            end else begin
              audio_count_d = count_inc[IntervalW-1:0];
            end
          end
        endcase
      end
    end
    res.cnt = n;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_count_q <= '0;
      phase_q       <= PH_AUDIO;
      meta_rem_q    <= '0;
      prefix_q      <= '0;
      title_q       <= TP_SEARCH;
      quote_q       <= 1'b0;
      nonempty_q    <= 1'b0;
    end else begin
      audio_count_q <= audio_count_d;
      phase_q       <= phase_d;
      meta_rem_q    <= meta_rem_d;
      prefix_q      <= prefix_d;
      title_q       <= title_d;
      quote_q       <= quote_d;
      nonempty_q    <= nonempty_d;
    end
  end

endmodule

/* design/imsd_out_fifo.sv */
// result queue: takes up to three results per cycle, hands out one per cycle while ready_i is high
// depends on imsd_pkg
module imsd_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  imsd_pkg::results_t wr_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output imsd_pkg::entry_t   head_o
);
  import imsd_pkg::*;

  entry_t          mem_q [FifoDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_after_pop;
  logic            pop;

  assign valid_o         = (count_q != '0);
  assign pop             = valid_o && ready_i;
  assign count_after_pop = count_q - CntW'(pop);
  assign room_o          = (count_after_pop <= CntW'(FifoDepth - MaxResults));
  assign head_o          = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (2'(i) < wr_i.cnt) begin
        mem_q[wptr_q + PtrW'(i)] <= '{kind: wr_i.item[i].kind,
                                      data: wr_i.item[i].data,
                                      last: (2'(i) == wr_i.cnt - 2'd1)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PtrW'(wr_i.cnt);
      rptr_q  <= rptr_q + PtrW'(pop);
      count_q <= count_after_pop + CntW'(wr_i.cnt);
    end
  end

endmodule

/* design/icy_metadata_stream_demux_top.sv */
// top level of the icy metadata stream demux: input register, parser, result queue
// depends on imsd_pkg, imsd_parser, imsd_out_fifo
//
// usage
// - slave stream carries one raw stream byte per transaction in tdata
// - master stream returns results: tdata the audio or title byte (zero for
//   markers), tuser the kind (audio, title byte, title committed, title
//   discarded), tlast on the final result caused by one input byte
// - an input byte causes zero to three results
// - cfg_we_i writes the metadata interval; zero passes every byte as audio;
//   write only while the block is idle
// - an input byte passes from the input register through the parser into the result queue
// - throughput: one input byte per cycle while each byte yields at most one
//   result and m_axis_tready is high; the master side drains one result per cycle
//   while m_axis_tready is high, so bytes that yield several results hold the input back
// - the parser takes a byte only when the four-entry result queue can absorb
//   three results, so a master stall backs up into s_axis_tready
// - reset clears the interval, all parser state and the queue; no clearing
//   pass is needed
module icy_metadata_stream_demux_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [imsd_pkg::IntervalW-1:0] cfg_wdata_i,    // meta_interval
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [imsd_pkg::ByteW-1:0]     s_axis_tdata,   // [7:0] in_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [imsd_pkg::ByteW-1:0]     m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]                     m_axis_tuser,   // [1:0] kind
  output logic                           m_axis_tlast    // last_of_run
);
  import imsd_pkg::*;

  logic [IntervalW-1:0] interval_q;
  logic                 in_valid_q;
  logic [ByteW-1:0]     in_byte_q;
  logic                 room;
  logic                 proc;
  results_t             res;
  entry_t               head;

  assign proc          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      in_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  imsd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .meta_interval_i(interval_q),
    .proc_i         (proc),
    .byte_i         (in_byte_q),
    .res_o          (res)
  );

  imsd_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .head_o (head)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

/* design/imsd_checker.sv */
// port-level checks for the icy metadata stream demux, bound to the top level
// depends on imsd_pkg and icy_metadata_stream_demux_top
module imsd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [imsd_pkg::ByteW-1:0] m_axis_tdata,
  input logic [1:0]                 m_axis_tuser,
  input logic                       m_axis_tlast
);
  import imsd_pkg::*;

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // markers carry no byte
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_COMMIT || m_axis_tuser == KIND_DISCARD)
      |-> m_axis_tdata == '0)
    else $error("marker with nonzero data");

  // markers end the run of their byte
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_COMMIT || m_axis_tuser == KIND_DISCARD)
      |-> m_axis_tlast)
    else $error("marker without tlast");

  // a zero byte never appears inside a title
  a_title_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_TITLE |-> m_axis_tdata != '0)
    else $error("zero title byte");

endmodule

bind icy_metadata_stream_demux_top imsd_checker u_imsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
